/* hw/rtl/hpr_pkg.sv */
// Shared types, constants and orientation tables for the Hilbert prefix mapper.
`default_nettype none

package hpr_pkg;

    localparam int ADDR_BITS   = 128;
    localparam int HALF_W      = ADDR_BITS / 2;
    localparam int PAIR_STAGES = ADDR_BITS / 2;
    localparam int CNT_W       = $clog2(PAIR_STAGES + 1);
    localparam int IDX_W       = $clog2(PAIR_STAGES);
    localparam int FRAC_BITS   = 48;
    localparam int DIM_W       = 16;
    localparam int GEOM_W      = FRAC_BITS + DIM_W;
    localparam int LEN_W       = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = DIM_W;

    typedef logic [1:0] orient_t;
    typedef logic [1:0] quad_t;

    typedef enum logic [1:0] {
        DIR_DOWN  = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_UP    = 2'd2,
        DIR_RIGHT = 2'd3
    } dir_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FIRST_BIT    = 2'd0,
        REG_LAST_BIT     = 2'd1,
        REG_IMAGE_WIDTH  = 2'd2,
        REG_IMAGE_HEIGHT = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic ok;
        dir_t dir;
    } hpr_grow_t;

    // One item in flight through the pair stages.
    typedef struct packed {
        logic [ADDR_BITS-1:0] addr;      // remaining bits, next pair at the top
        logic [GEOM_W-1:0]    x;
        logic [GEOM_W-1:0]    y;
        logic [GEOM_W-1:0]    w;
        logic [GEOM_W-1:0]    h;
        logic [CNT_W-1:0]     npairs;    // pairs this item walks
        logic                 grow_end;  // prefix ends on the first bit of the last pair
        orient_t              orient;
        logic                 grow_pend;
        dir_t                 grow_dir;
        logic                 bad;
    } hpr_stage_t;

    typedef struct packed {
        logic [GEOM_W-1:0] x;
        logic [GEOM_W-1:0] y;
        logic [GEOM_W-1:0] w;
        logic [GEOM_W-1:0] h;
        logic              bad;
    } hpr_rect_t;

    localparam orient_t NEXT_ORIENT [4][4] = '{
        '{2'd3, 2'd0, 2'd0, 2'd1},
        '{2'd2, 2'd1, 2'd1, 2'd0},
        '{2'd1, 2'd2, 2'd2, 2'd3},
        '{2'd0, 2'd3, 2'd3, 2'd2}
    };

    function automatic logic x_hit(input orient_t o, input quad_t p);
        logic r;
        case (o)
            2'd0:    r = (p == 2'd2) || (p == 2'd3);
            2'd1:    r = (p == 2'd0) || (p == 2'd3);
            2'd2:    r = (p == 2'd0) || (p == 2'd1);
            default: r = (p == 2'd1) || (p == 2'd2);
        endcase
        return r;
    endfunction

    function automatic logic y_hit(input orient_t o, input quad_t p);
        logic r;
        case (o)
            2'd0:    r = (p == 2'd1) || (p == 2'd2);
            2'd1:    r = (p == 2'd0) || (p == 2'd1);
            2'd2:    r = (p == 2'd0) || (p == 2'd3);
            default: r = (p == 2'd2) || (p == 2'd3);
        endcase
        return r;
    endfunction

    // Only even quadrants allow the cell to grow back.
    function automatic hpr_grow_t grow_lookup(input orient_t o, input quad_t p);
        hpr_grow_t g;
        case (p)
            2'd0:    begin g.ok = 1'b1; g.dir = dir_t'(o); end
            2'd2:    begin g.ok = 1'b1; g.dir = dir_t'(o ^ 2'd2); end
            default: begin g.ok = 1'b0; g.dir = DIR_DOWN; end
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/hpr_ifs.sv */
// Valid/ready channel interfaces for prefix items and rectangle items.
`default_nettype none

interface hpr_in_if;
    logic                       valid;
    logic                       ready;
    logic [hpr_pkg::HALF_W-1:0] addr_upper;
    logic [hpr_pkg::HALF_W-1:0] addr_lower;
    logic [hpr_pkg::LEN_W-1:0]  prefix_len;

    modport source (output valid, output addr_upper, output addr_lower,
                    output prefix_len, input ready);
    modport sink   (input valid, input addr_upper, input addr_lower,
                    input prefix_len, output ready);
endinterface

interface hpr_out_if;
    logic                       valid;
    logic                       ready;
    logic [hpr_pkg::GEOM_W-1:0] rect_x;
    logic [hpr_pkg::GEOM_W-1:0] rect_y;
    logic [hpr_pkg::GEOM_W-1:0] rect_w;
    logic [hpr_pkg::GEOM_W-1:0] rect_h;
    logic                       bad_prefix;

    modport source (output valid, output rect_x, output rect_y, output rect_w,
                    output rect_h, output bad_prefix, input ready);
    modport sink   (input valid, input rect_x, input rect_y, input rect_w,
                    input rect_h, input bad_prefix, output ready);
endinterface

`default_nettype wire

/* hw/rtl/hpr_entry.sv */
// Entry stage: aligns the address to the start bit and works out the pair count.
`default_nettype none

module hpr_entry (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        adv,
    input  wire logic                        in_valid,
    input  wire logic [hpr_pkg::HALF_W-1:0]  addr_upper,
    input  wire logic [hpr_pkg::HALF_W-1:0]  addr_lower,
    input  wire logic [hpr_pkg::LEN_W-1:0]   prefix_len,
    input  wire logic [hpr_pkg::LEN_W-1:0]   first_bit,
    input  wire logic [hpr_pkg::LEN_W-1:0]   last_bit,
    input  wire logic [hpr_pkg::DIM_W-1:0]   image_width,
    input  wire logic [hpr_pkg::DIM_W-1:0]   image_height,
    output logic                             out_valid,
    output hpr_pkg::hpr_stage_t              out_data
);
    import hpr_pkg::*;

    localparam int AW = LEN_W + 2;

    logic [LEN_W-1:0] size;
    logic [AW-1:0]    fb_e;
    logic [AW-1:0]    lb_e;
    logic [AW-1:0]    sz_e;
    logic             walk_ok;
    logic [AW-1:0]    n_last;
    logic [AW-1:0]    n_size;
    logic [AW-1:0]    n_pairs;
    logic             valid_reg;
    logic             valid_next;
    hpr_stage_t       data_reg;
    hpr_stage_t       data_next;

    always_comb
    begin
        size    = (prefix_len > LEN_W'(ADDR_BITS)) ? LEN_W'(ADDR_BITS) : prefix_len;
        fb_e    = AW'(first_bit);
        lb_e    = AW'(last_bit);
        sz_e    = AW'(size);
        walk_ok = (fb_e + AW'(1) <= lb_e) && (fb_e < sz_e);
        // pairs allowed by last_bit and by the prefix length; the walk takes the fewer
        n_last  = ((lb_e - fb_e - AW'(1)) >> 1) + AW'(1);
        n_size  = ((sz_e - fb_e - AW'(1)) >> 1) + AW'(1);
        if (!walk_ok)
            n_pairs = '0;
        else if (n_last < n_size)
            n_pairs = n_last;
        else
            n_pairs = n_size;

        data_next.addr      = {addr_upper, addr_lower} << first_bit;
        data_next.x         = '0;
        data_next.y         = '0;
        data_next.w         = {image_width, FRAC_BITS'(0)};
        data_next.h         = {image_height, FRAC_BITS'(0)};
        data_next.npairs    = n_pairs[CNT_W-1:0];
        data_next.grow_end  = walk_ok && (fb_e + (n_pairs << 1) - AW'(1) == sz_e);
        data_next.orient    = '0;
        data_next.grow_pend = 1'b0;
        data_next.grow_dir  = DIR_DOWN;
        data_next.bad       = 1'b0;

        valid_next = adv ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

/* hw/rtl/hpr_pair_stage.sv */
// One bit pair of the Hilbert walk: offsets, halving and orientation step.
`default_nettype none

module hpr_pair_stage (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      adv,
    input  wire logic [hpr_pkg::IDX_W-1:0] stage_idx,
    input  wire logic                      in_valid,
    input  wire hpr_pkg::hpr_stage_t       in_data,
    output logic                           out_valid,
    output hpr_pkg::hpr_stage_t            out_data
);
    import hpr_pkg::*;

    logic              active;
    logic              last;
    quad_t             pos;
    logic [GEOM_W-1:0] ox;
    logic [GEOM_W-1:0] oy;
    hpr_grow_t         grow;
    logic              valid_reg;
    logic              valid_next;
    hpr_stage_t        data_reg;
    hpr_stage_t        data_next;

    always_comb
    begin
        active = in_data.npairs > CNT_W'(stage_idx);
        last   = in_data.npairs == CNT_W'(stage_idx) + CNT_W'(1);
        pos    = in_data.addr[ADDR_BITS-1 -: 2];
        ox     = in_data.w >> 1;
        oy     = in_data.h >> 1;
        grow   = grow_lookup(in_data.orient, pos);

        data_next      = in_data;
        data_next.addr = in_data.addr << 2;
        if (active)
        begin
            if (x_hit(in_data.orient, pos))
                data_next.x = in_data.x + ox;
            if (y_hit(in_data.orient, pos))
                data_next.y = in_data.y + oy;
            data_next.w      = in_data.w >> 1;
            data_next.h      = in_data.h >> 1;
            data_next.orient = NEXT_ORIENT[in_data.orient][pos];
            // the grow itself is applied after the last pair stage
            if (last && in_data.grow_end)
            begin
                if (grow.ok)
                begin
                    data_next.grow_pend = 1'b1;
                    data_next.grow_dir  = grow.dir;
                end
                else
                begin
                    data_next.bad = 1'b1;
                end
            end
        end

        valid_next = adv ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

/* hw/rtl/hpr_grow.sv */
// Final stage: pending grow doubles the cell one way; left/up shifts saturate at 0.
`default_nettype none

module hpr_grow (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                adv,
    input  wire logic                in_valid,
    input  wire hpr_pkg::hpr_stage_t in_data,
    output logic                     out_valid,
    output hpr_pkg::hpr_rect_t       out_data
);
    import hpr_pkg::*;

    logic [GEOM_W-1:0] w_new;
    logic [GEOM_W-1:0] h_new;
    logic [GEOM_W-1:0] w_half;
    logic [GEOM_W-1:0] h_half;
    logic              valid_reg;
    logic              valid_next;
    hpr_rect_t         data_reg;
    hpr_rect_t         data_next;

    always_comb
    begin
        w_new = in_data.w;
        h_new = in_data.h;
        if (in_data.grow_pend)
        begin
            if (in_data.grow_dir[0])
                w_new = in_data.w << 1;
            else
                h_new = in_data.h << 1;
        end
        w_half = w_new >> 1;
        h_half = h_new >> 1;

        data_next.x   = in_data.x;
        data_next.y   = in_data.y;
        data_next.w   = w_new;
        data_next.h   = h_new;
        data_next.bad = in_data.bad;
        if (in_data.grow_pend && in_data.grow_dir == DIR_LEFT)
            data_next.x = (in_data.x > w_half) ? in_data.x - w_half : '0;
        else if (in_data.grow_pend && in_data.grow_dir == DIR_UP)
            data_next.y = (in_data.y > h_half) ? in_data.y - h_half : '0;

        valid_next = adv ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

/* hw/rtl/hpr_out_buf.sv */
// Output register plus skid entry; the pipeline stalls only when the skid entry is full.
`default_nettype none

module hpr_out_buf (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire hpr_pkg::hpr_rect_t in_data,
    output logic                    adv,
    hpr_out_if.source               rect
);
    import hpr_pkg::*;

    logic      out_valid_reg;
    logic      out_valid_next;
    hpr_rect_t out_data_reg;
    hpr_rect_t out_data_next;
    logic      skid_valid_reg;
    logic      skid_valid_next;
    hpr_rect_t skid_data_reg;
    hpr_rect_t skid_data_next;
    logic      take;

    assign adv  = !skid_valid_reg;
    assign take = adv && in_valid;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (rect.ready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = take;
                if (take)
                    out_data_next = in_data;
            end
        end
        else if (take)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign rect.valid      = out_valid_reg;
    assign rect.rect_x     = out_data_reg.x;
    assign rect.rect_y     = out_data_reg.y;
    assign rect.rect_w     = out_data_reg.w;
    assign rect.rect_h     = out_data_reg.h;
    assign rect.bad_prefix = out_data_reg.bad;

endmodule

`default_nettype wire

/* hw/rtl/hilbert_prefix_to_rectangle_core.sv */
// Hilbert prefix to rectangle mapper: 128-bit prefixes in, image rectangles out.
//
// prefix (valid/ready sink) takes addr_upper, addr_lower and prefix_len; rect
// (valid/ready source) gives rect_x, rect_y, rect_w, rect_h in unsigned 16.48
// pixels and bad_prefix. Each accepted prefix gives exactly one rectangle, in order.
// The cfg port (cfg_we, cfg_index, cfg_data) writes first_bit, last_bit,
// image_width and image_height; write it only while no item is in flight.
// Pipeline: one entry stage, one stage per bit pair (64), one grow stage and the
// output register. Throughput is one item per cycle while the skid entry is
// empty; every stage moves on a shared advance that depends only on the skid
// entry at the output.
// When rect is stalled the next result goes into the skid entry and prefix
// stays ready; only when both output entries are full does prefix.ready drop,
// and it comes back the cycle after the receiver takes a result.
// Reset clears all valid bits and loads first_bit 0, last_bit 128 and a
// 4096 by 4096 image.
`default_nettype none

module hilbert_prefix_to_rectangle_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    hpr_in_if.sink                             prefix,
    hpr_out_if.source                          rect,
    input  wire logic                          cfg_we,
    input  wire logic [hpr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [hpr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import hpr_pkg::*;

    logic [LEN_W-1:0] first_bit_reg;
    logic [LEN_W-1:0] last_bit_reg;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic             adv;

    logic             stg_valid [PAIR_STAGES+1];
    hpr_stage_t       stg_data  [PAIR_STAGES+1];
    logic             grow_valid;
    hpr_rect_t        grow_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_bit_reg <= '0;
            last_bit_reg  <= LEN_W'(ADDR_BITS);
            width_reg     <= DIM_W'(4096);
            height_reg    <= DIM_W'(4096);
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FIRST_BIT:    first_bit_reg <= cfg_data[LEN_W-1:0];
                REG_LAST_BIT:     last_bit_reg  <= cfg_data[LEN_W-1:0];
                REG_IMAGE_WIDTH:  width_reg     <= cfg_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT: height_reg    <= cfg_data[DIM_W-1:0];
                default:          ;
            endcase
        end
    end

    assign prefix.ready = adv;

    hpr_entry u_entry (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .in_valid     (prefix.valid),
        .addr_upper   (prefix.addr_upper),
        .addr_lower   (prefix.addr_lower),
        .prefix_len   (prefix.prefix_len),
        .first_bit    (first_bit_reg),
        .last_bit     (last_bit_reg),
        .image_width  (width_reg),
        .image_height (height_reg),
        .out_valid    (stg_valid[0]),
        .out_data     (stg_data[0])
    );

    for (genvar k = 0; k < PAIR_STAGES; k++)
    begin : g_pair
        hpr_pair_stage u_pair (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .stage_idx (IDX_W'(k)),
            .in_valid  (stg_valid[k]),
            .in_data   (stg_data[k]),
            .out_valid (stg_valid[k+1]),
            .out_data  (stg_data[k+1])
        );
    end

    hpr_grow u_grow (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (stg_valid[PAIR_STAGES]),
        .in_data   (stg_data[PAIR_STAGES]),
        .out_valid (grow_valid),
        .out_data  (grow_data)
    );

    hpr_out_buf u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (grow_valid),
        .in_data  (grow_data),
        .adv      (adv),
        .rect     (rect)
    );

endmodule

`default_nettype wire

/* hw/rtl/hpr_checker.sv */
// Port-level checks for the Hilbert prefix mapper, bound to the top level.
`default_nettype none

module hpr_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       in_ready,
    input wire logic                       out_valid,
    input wire logic                       out_ready,
    input wire logic [hpr_pkg::GEOM_W-1:0] rect_x,
    input wire logic [hpr_pkg::GEOM_W-1:0] rect_w,
    input wire logic                       bad_prefix
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("rect item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(rect_x) && $stable(rect_w) && $stable(bad_prefix))
        else $error("rect payload changed while stalled");

    // input backpressure only when the output side is itself holding an item
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("prefix not ready with no result waiting");

    a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready && out_ready |=> in_ready)
        else $error("prefix stayed stalled after a result was taken");

endmodule

bind hilbert_prefix_to_rectangle_core hpr_checker u_hpr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (prefix.ready),
    .out_valid  (rect.valid),
    .out_ready  (rect.ready),
    .rect_x     (rect.rect_x),
    .rect_w     (rect.rect_w),
    .bad_prefix (rect.bad_prefix)
);

`default_nettype wire
